// ----- rtl/efc_pkg.sv -----
// Package for the fly camera: shared widths, reset values, register indexes
// and the CORDIC arctangent table. No dependencies.
package efc_pkg;
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] RegMoveSpeed = 1'b0;
  localparam logic [CfgIdxW-1:0] RegLookSens = 1'b1;

  localparam logic [15:0] MoveSpeedRst = 16'd640;
  localparam logic [15:0] LookSensRst = 16'd6554;

  localparam logic signed [24:0] YawRst = -25'sd5898240;
  localparam logic signed [31:0] PosZRst = 32'sd196608;
  localparam logic signed [24:0] YawHalf = 25'sd11796480;
  localparam logic signed [26:0] YawFull = 27'sd23592960;
  localparam logic signed [23:0] PitchLim = 24'sd5832704;
  localparam logic signed [24:0] Quarter = 25'sd5898240;
  localparam logic signed [33:0] CordicK = 34'sd652032874;

  localparam logic [1:0] DirFwd = 2'd0;
  localparam logic [1:0] DirBack = 2'd1;
  localparam logic [1:0] DirLeft = 2'd2;
  localparam logic [1:0] DirRight = 2'd3;

  localparam int unsigned TableLen = 24;

  function automatic logic [29:0] atan_deg(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0: r = 30'd754974720;
      5'd1: r = 30'd445687602;
      5'd2: r = 30'd235489088;
      5'd3: r = 30'd119537938;
      5'd4: r = 30'd60000934;
      5'd5: r = 30'd30029717;
      5'd6: r = 30'd15018523;
      5'd7: r = 30'd7509720;
      5'd8: r = 30'd3754917;
      5'd9: r = 30'd1877466;
      5'd10: r = 30'd938734;
      5'd11: r = 30'd469367;
      5'd12: r = 30'd234684;
      5'd13: r = 30'd117342;
      5'd14: r = 30'd58671;
      5'd15: r = 30'd29335;
      5'd16: r = 30'd14668;
      5'd17: r = 30'd7334;
      5'd18: r = 30'd3667;
      5'd19: r = 30'd1833;
      5'd20: r = 30'd917;
      5'd21: r = 30'd458;
      5'd22: r = 30'd229;
      5'd23: r = 30'd115;
      default: r = 30'd0;
    endcase
    return r;
  endfunction
endpackage

// ----- rtl/efc_if.sv -----
// Valid/ready channel interfaces for the fly camera.
// Depends on efc_pkg for the register index width.
interface efc_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [1:0] move_dir;
  logic [15:0] delta_time;
  logic signed [15:0] mouse_dx;
  logic signed [15:0] mouse_dy;
  modport source(output valid, req_type, move_dir, delta_time, mouse_dx, mouse_dy,
                 input ready);
  modport sink(input valid, req_type, move_dir, delta_time, mouse_dx, mouse_dy,
               output ready);
endinterface

interface efc_res_if;
  logic valid;
  logic ready;
  logic signed [31:0] cam_x;
  logic signed [31:0] cam_y;
  logic signed [31:0] cam_z;
  logic signed [15:0] fwd_x;
  logic signed [15:0] fwd_y;
  logic signed [15:0] fwd_z;
  logic signed [15:0] side_x;
  logic signed [15:0] side_z;
  logic signed [24:0] yaw_deg;
  logic signed [23:0] pitch_deg;
  modport source(output valid, cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z, side_x,
                 side_z, yaw_deg, pitch_deg, input ready);
  modport sink(input valid, cam_x, cam_y, cam_z, fwd_x, fwd_y, fwd_z, side_x,
               side_z, yaw_deg, pitch_deg, output ready);
endinterface

interface efc_cfg_if;
  logic valid;
  logic ready;
  logic [efc_pkg::CfgIdxW-1:0] index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/euler_fly_camera.sv -----
// Fly camera top level: position, yaw and pitch state with a shared
// multiplier and CORDIC sequencer. Depends on efc_pkg and efc_if.
//
//   channel   dir  handshake      carries
//   req       in   valid/ready    req_type, move_dir, delta_time, mouse_dx/dy
//   res       out  valid/ready    position, forward, right, yaw, pitch
//   cfg       in   valid/ready    register index, 16-bit data
//
// A move item runs one multiply for velocity, then a multiply and a saturating
// update per axis, then the load.
// A look item runs two offset multiplies, 11 yaw reduction steps, two CORDIC
// runs on one add/shift datapath (iterations capped at 24) and two partial
// products for each of the x and z forward terms.
// Reset restores the start pose; no clearing pass is needed.
// The request side stays low while an item is in work; the result register
// holds until taken, and the next item is accepted as it is taken.
module euler_fly_camera #(
  parameter int unsigned CORDIC_ITERATIONS = 16
) (
  input logic clk_i,
  input logic rst_ni,
  efc_req_if.sink req,
  efc_res_if.source res,
  efc_cfg_if.sink cfg
);
  localparam int unsigned NIter = (CORDIC_ITERATIONS < efc_pkg::TableLen) ?
                                  CORDIC_ITERATIONS : efc_pkg::TableLen;
  localparam logic [4:0] LastIter = 5'(NIter - 1);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SVel = 4'd1;
  localparam logic [3:0] SMovA = 4'd2;
  localparam logic [3:0] SLook = 4'd5;
  localparam logic [3:0] SAng = 4'd6;
  localparam logic [3:0] SCordY = 4'd7;
  localparam logic [3:0] SCordP = 4'd8;
  localparam logic [3:0] SVecA = 4'd9;
  localparam logic [3:0] SVecB = 4'd10;
  localparam logic [3:0] SVecC = 4'd11;
  localparam logic [3:0] SOut = 4'd12;
  localparam logic [3:0] SLookB = 4'd13;
  localparam logic [3:0] SMovD = 4'd14;

  logic [3:0] st_q, st_d;
  logic [15:0] speed_q, sens_q;
  logic signed [31:0] px_q, py_q, pz_q;
  logic signed [24:0] yaw_q;
  logic signed [23:0] pitch_q;
  logic signed [15:0] fx_q, fy_q, fz_q, rx_q, rz_q;
  logic [1:0] dir_q;
  logic [15:0] dt_q;
  logic signed [15:0] dx_q, dy_q;
  logic [31:0] vel_q;
  logic signed [33:0] cx_q, cy_q;
  logic signed [31:0] cz_q;
  logic cneg_q;
  logic [4:0] it_q;
  logic [1:0] ax_q;
  logic signed [33:0] sy_q, cyaw_q;
  logic signed [48:0] prod_q;
  logic signed [40:0] lyaw_q, lpitch_q;
  logic res_valid_q;

  // Shared 34x17 signed multiplier.
  logic signed [33:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [50:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic signed [15:0] vec_sel;
  logic sgn_neg;
  always_comb begin
    vec_sel = 16'sd0;
    sgn_neg = (dir_q == efc_pkg::DirBack) || (dir_q == efc_pkg::DirLeft);
    if (dir_q == efc_pkg::DirFwd || dir_q == efc_pkg::DirBack) begin
      unique case (ax_q)
        2'd0: vec_sel = fx_q;
        2'd1: vec_sel = fy_q;
        default: vec_sel = fz_q;
      endcase
    end else begin
      unique case (ax_q)
        2'd0: vec_sel = rx_q;
        2'd1: vec_sel = 16'sd0;
        default: vec_sel = rz_q;
      endcase
    end
  end

  // The yaw terms times cos(pitch) are built from two partial products:
  // the low 16 bits of cos(pitch) unsigned, then the high part shifted.
  logic signed [33:0] vm_a;
  logic signed [16:0] vm_lo, vm_hi;
  assign vm_a = (ax_q == 2'd0) ? cyaw_q : sy_q;
  assign vm_lo = $signed({1'b0, cx_q[15:0]});
  assign vm_hi = 17'(cx_q >>> 16);

  always_comb begin
    mul_a = 34'sd0;
    mul_b = 17'sd0;
    unique case (st_q)
      SVel: begin
        mul_a = 34'(dt_q);
        mul_b = $signed({1'b0, speed_q});
      end
      SMovA: begin
        mul_a = 34'(vel_q);
        mul_b = sgn_neg ? -17'(vec_sel) : 17'(vec_sel);
      end
      SLook: begin
        mul_a = 34'(dx_q);
        mul_b = $signed({1'b0, sens_q});
      end
      SLookB: begin
        mul_a = 34'(dy_q);
        mul_b = $signed({1'b0, sens_q});
      end
      SVecA: begin
        mul_a = vm_a;
        mul_b = vm_lo;
      end
      SVecB: begin
        mul_a = vm_a;
        mul_b = vm_hi;
      end
      default: begin
        mul_a = 34'sd0;
        mul_b = 17'sd0;
      end
    endcase
  end

  logic signed [67:0] vacc_q;

  // CORDIC datapath.
  logic signed [33:0] sx, sy;
  logic signed [33:0] cx_n, cy_n;
  logic signed [31:0] cz_n;
  always_comb begin
    sx = cy_q >>> it_q;
    sy = cx_q >>> it_q;
    if (!cz_q[31]) begin
      cx_n = cx_q - sx;
      cy_n = cy_q + sy;
      cz_n = cz_q - $signed({2'b00, efc_pkg::atan_deg(it_q)});
    end else begin
      cx_n = cx_q + sx;
      cy_n = cy_q - sy;
      cz_n = cz_q + $signed({2'b00, efc_pkg::atan_deg(it_q)});
    end
  end

  function automatic logic signed [15:0] q15(input logic signed [67:0] v,
                                              input int unsigned k);
    logic signed [67:0] r;
    r = (v + (68'sd1 <<< (k - 1))) >>> k;
    if (r > 68'sd32767) return 16'sd32767;
    if (r < -68'sd32768) return -16'sd32768;
    return r[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
    if (v > 34'sd2147483647) return 32'sh7fffffff;
    if (v < -34'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // Angle load with fold beyond a quarter turn.
  function automatic logic signed [31:0] fold_ang(input logic signed [24:0] a);
    logic signed [25:0] t;
    t = 26'(a);
    if (a > efc_pkg::Quarter) t = t - 26'(2 * 5898240);
    else if (a < -efc_pkg::Quarter) t = t + 26'(2 * 5898240);
    return 32'(t) <<< 8;
  endfunction

  function automatic logic fold_neg(input logic signed [24:0] a);
    return (a > efc_pkg::Quarter) || (a < -efc_pkg::Quarter);
  endfunction

  function automatic logic signed [24:0] ywrap_fin(input logic signed [41:0] r);
    logic signed [41:0] t;
    t = r;
    if (t < 42'sd0) t = t + 42'(efc_pkg::YawFull);
    return 25'(t - 42'(efc_pkg::YawHalf));
  endfunction

  logic signed [33:0] pos_cur;
  logic signed [33:0] step_r;
  always_comb begin
    unique case (ax_q)
      2'd0: pos_cur = 34'(px_q);
      2'd1: pos_cur = 34'(py_q);
      default: pos_cur = 34'(pz_q);
    endcase
    step_r = 34'((prod_q + 49'sd4194304) >>> 23);
  end

  logic signed [41:0] pnew;
  assign pnew = 42'(pitch_q) + 42'(lpitch_q);

  // Yaw reduction runs iteratively: subtract or add 2^k turns, k descending.
  logic signed [41:0] yr_q;
  logic [4:0] yk_q;
  logic signed [41:0] ystep;
  logic signed [41:0] yr_nx;
  assign ystep = 42'(efc_pkg::YawFull) <<< yk_q;
  always_comb begin
    yr_nx = yr_q;
    if (yr_q >= ystep) yr_nx = yr_q - ystep;
    else if (yr_q < -ystep) yr_nx = yr_q + ystep;
  end

  assign req.ready = (st_q == SIdle) && (!res_valid_q || res.ready);
  assign cfg.ready = 1'b1;

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      SIdle: if (req.valid && req.ready) st_d = req.req_type ? SLook : SVel;
      SVel: st_d = SMovA;
      SMovA: st_d = SMovD;
      SMovD: st_d = (ax_q == 2'd2) ? SOut : SMovA;
      SLook: st_d = SLookB;
      SLookB: st_d = SAng;
      SAng: st_d = (yk_q == 5'd0) ? SCordY : SAng;
      SCordY: st_d = (it_q == LastIter) ? SCordP : SCordY;
      SCordP: st_d = (it_q == LastIter) ? SVecA : SCordP;
      SVecA: st_d = SVecB;
      SVecB: st_d = SVecC;
      SVecC: st_d = (ax_q == 2'd2) ? SOut : SVecA;
      SOut: st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      res_valid_q <= 1'b0;
      speed_q <= efc_pkg::MoveSpeedRst;
      sens_q <= efc_pkg::LookSensRst;
      px_q <= 32'sd0;
      py_q <= 32'sd0;
      pz_q <= efc_pkg::PosZRst;
      yaw_q <= efc_pkg::YawRst;
      pitch_q <= 24'sd0;
      fx_q <= 16'sd0;
      fy_q <= 16'sd0;
      fz_q <= -16'sd32768;
      rx_q <= 16'sd32767;
      rz_q <= 16'sd0;
    end else begin
      st_q <= st_d;
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == efc_pkg::RegMoveSpeed) speed_q <= cfg.data;
        else if (cfg.index == efc_pkg::RegLookSens) sens_q <= cfg.data;
      end
      if (st_q == SOut) res_valid_q <= 1'b1;
      else if (res.ready) res_valid_q <= 1'b0;
      unique case (st_q)
        SMovD: begin
          unique case (ax_q)
            2'd0: px_q <= sat32(pos_cur + step_r);
            2'd1: py_q <= sat32(pos_cur + step_r);
            default: pz_q <= sat32(pos_cur + step_r);
          endcase
        end
        SAng: begin
          if (yk_q == 5'd0) begin
            yaw_q <= ywrap_fin(yr_nx);
            if (pnew > 42'(efc_pkg::PitchLim)) pitch_q <= efc_pkg::PitchLim;
            else if (pnew < -42'(efc_pkg::PitchLim)) pitch_q <= -efc_pkg::PitchLim;
            else pitch_q <= pnew[23:0];
          end
        end
        SCordP: begin
          if (it_q == 5'd0) begin
            rx_q <= q15(-68'(sy_q), 15);
            rz_q <= q15(68'(cyaw_q), 15);
          end
          if (it_q == LastIter)
            fy_q <= q15(68'(cneg_q ? -cy_n : cy_n), 15);
        end
        SVecC: begin
          if (ax_q == 2'd0) fx_q <= q15(vacc_q, 45);
          else fz_q <= q15(vacc_q, 45);
        end
        default: ;
      endcase
    end
  end

  // Working registers, no reset needed.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      SIdle: begin
        dir_q <= req.move_dir;
        dt_q <= req.delta_time;
        dx_q <= req.mouse_dx;
        dy_q <= req.mouse_dy;
        ax_q <= 2'd0;
      end
      SVel: vel_q <= mul_p[31:0];
      SMovA: prod_q <= mul_p[48:0];
      SMovD: ax_q <= ax_q + 2'd1;
      SLook: lyaw_q <= 41'(mul_p);
      SLookB: begin
        lpitch_q <= 41'(mul_p);
        yk_q <= 5'd10;
        yr_q <= 42'(yaw_q) + 42'(lyaw_q) + 42'(efc_pkg::YawHalf);
      end
      SAng: begin
        yr_q <= yr_nx;
        if (yk_q != 5'd0) yk_q <= yk_q - 5'd1;
        else begin
          cx_q <= efc_pkg::CordicK;
          cy_q <= 34'sd0;
          cz_q <= fold_ang(ywrap_fin(yr_nx));
          cneg_q <= fold_neg(ywrap_fin(yr_nx));
          it_q <= 5'd0;
        end
      end
      SCordY: begin
        if (it_q == LastIter) begin
          sy_q <= cneg_q ? -cy_n : cy_n;
          cyaw_q <= cneg_q ? -cx_n : cx_n;
          cx_q <= efc_pkg::CordicK;
          cy_q <= 34'sd0;
          cz_q <= fold_ang(25'(pitch_q));
          cneg_q <= 1'b0;
          it_q <= 5'd0;
        end else begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          it_q <= it_q + 5'd1;
        end
      end
      SCordP: begin
        if (it_q == LastIter) begin
          cx_q <= cx_n;
          ax_q <= 2'd0;
        end else begin
          cx_q <= cx_n;
          cy_q <= cy_n;
          cz_q <= cz_n;
          it_q <= it_q + 5'd1;
        end
      end
      SVecA: vacc_q <= 68'(mul_p);
      SVecB: vacc_q <= vacc_q + (68'(mul_p) <<< 16);
      SVecC: ax_q <= 2'd2;
      default: ;
    endcase
  end

  assign res.valid = res_valid_q;
  assign res.cam_x = px_q;
  assign res.cam_y = py_q;
  assign res.cam_z = pz_q;
  assign res.fwd_x = fx_q;
  assign res.fwd_y = fy_q;
  assign res.fwd_z = fz_q;
  assign res.side_x = rx_q;
  assign res.side_z = rz_q;
  assign res.yaw_deg = yaw_q;
  assign res.pitch_deg = pitch_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> !req.ready)
    else $error("request taken while busy");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pitch_q <= efc_pkg::PitchLim) && (pitch_q >= -efc_pkg::PitchLim))
    else $error("pitch out of range");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (yaw_q < efc_pkg::YawHalf) && (yaw_q >= -efc_pkg::YawHalf))
    else $error("yaw not wrapped");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == SOut) |=> res_valid_q)
    else $error("result lost");
endmodule
